### src/rtpfc_pkg.sv
package rtpfc_pkg;

    // Default build values
    localparam int REGIONS_DEF    = 16;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int VADDR_BITS_DEF = 48;

    // Fixed field widths
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 48;
    localparam int FRAME_W     = 40;
    localparam int IDX_OUT_W   = 4;
    localparam int PN_OUT_W    = 36;
    localparam int FUNC_W      = 2;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        FN_ADD_ANON = 2'd0,
        FN_ADD_FILE = 2'd1,
        FN_CLEAR    = 2'd2,
        FN_FAULT    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_NO_REGION  = 4'd1,
        ACT_REFUSED    = 4'd2,
        ACT_SWAP_IN    = 4'd3,
        ACT_FILE_FILL  = 4'd4,
        ACT_SHARE_ZERO = 4'd5,
        ACT_FRESH      = 4'd6,
        ACT_COW        = 4'd7,
        ACT_TABLE      = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic               is_write;
        logic               swap;
        logic [FRAME_W-1:0] mapped;
    } t_fault_req;

    typedef struct packed {
        logic    status;
        t_action action;
        logic    map_writable;
    } t_verdict;

endpackage

### src/rtpfc_ram.sv
module rtpfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/rtpfc_decide.sv
module rtpfc_decide #(
    parameter int PW = 36
) (
    input  logic [PW-1:0]             i_page,
    input  logic [PW-1:0]             i_start,
    input  logic [PW:0]               i_end,
    input  logic                      i_write_ok,
    input  logic                      i_has_file,
    input  rtpfc_pkg::t_fault_req     i_req,
    input  logic [rtpfc_pkg::FRAME_W-1:0] i_zero_frame,
    output logic                      o_hit,
    output rtpfc_pkg::t_verdict       o_verdict
);
    import rtpfc_pkg::*;

    assign o_hit = (i_page >= i_start) && ({1'b0, i_page} < i_end);

    // absent: swap slot, file, zero page on read, else fresh; present: COW or refuse
    always_comb begin
        o_verdict = '{status: 1'b0, action: ACT_NONE, map_writable: 1'b0};
        priority if (i_req.mapped == '0) begin
            priority if (i_req.swap) begin
                o_verdict = '{status: 1'b0, action: ACT_SWAP_IN, map_writable: i_write_ok};
            end else if (i_has_file) begin
                o_verdict = '{status: 1'b0, action: ACT_FILE_FILL, map_writable: i_write_ok};
            end else if (!i_req.is_write) begin
                o_verdict = '{status: 1'b0, action: ACT_SHARE_ZERO, map_writable: 1'b0};
            end else begin
                o_verdict = '{status: 1'b0, action: ACT_FRESH, map_writable: i_write_ok};
            end
        end else if (i_req.is_write && (i_req.mapped == i_zero_frame) && i_write_ok) begin
            o_verdict = '{status: 1'b0, action: ACT_COW, map_writable: 1'b1};
        end else begin
            o_verdict = '{status: 1'b1, action: ACT_REFUSED, map_writable: 1'b0};
        end
    end

endmodule

### src/region_table_page_fault_classifier_top.sv
// Channel   Dir  Beat moves                 Bits (lowest first)
// s_axis    in   one request               tuser: func; tdata: address, size, writable,
//                                          is_write, mapped_frame, swap_slot_present
// m_axis    out  one result per request    tdata: status, action, region_index,
//                                          page_number, map_writable
// cfg       in   zero_frame write          i_cfg_wr_data, taken when i_cfg_wr_en
//
// Flow: a clear goes to the response state, an add through the add and response states,
// a fault through the scan and response states, scanning up to the first hit or the last
// filled entry; the result loads on leaving the response state, and the next request is
// taken in the idle state that follows. The region memory is read one entry a cycle.
// Reset clears the fill count, the state machine and the output valid; entries at
// or above the count are never read, so the memory needs no clearing pass.
// A stalled output holds its beat while the next request is accepted and worked on;
// that request waits in the response state until the output register frees.
module region_table_page_fault_classifier_top #(
    parameter int REGIONS    = rtpfc_pkg::REGIONS_DEF,
    parameter int PAGE_SHIFT = rtpfc_pkg::PAGE_SHIFT_DEF,
    parameter int VADDR_BITS = rtpfc_pkg::VADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request: tuser[1:0] func
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // request: [47:0] address, [95:48] size, [96] writable, [97] is_write,
    // [137:98] mapped_frame, [138] swap_slot_present, rest zero
    input  logic [rtpfc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [rtpfc_pkg::FUNC_W-1:0]      i_s_tuser,
    // result: [0] status, [4:1] action, [8:5] region_index, [44:9] page_number,
    // [45] map_writable, rest zero
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rtpfc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [rtpfc_pkg::FRAME_W-1:0]     i_cfg_wr_data
);
    import rtpfc_pkg::*;

    localparam int PW  = VADDR_BITS - PAGE_SHIFT;          // page number width
    localparam int EW  = PW + 1;                           // end page width
    localparam int IW  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CW  = $clog2(REGIONS + 1);
    localparam int SW  = ((VADDR_BITS > SIZE_W) ? VADDR_BITS : SIZE_W) + 2;
    localparam int EPW = SW - PAGE_SHIFT;
    localparam int MW  = PW + EW + 2;                      // memory word
    localparam logic [SW-1:0]  PAGE_MASK = (SW'(1) << PAGE_SHIFT) - SW'(1);
    localparam logic [EPW-1:0] TOP_PAGE  = EPW'(1) << PW;
    localparam logic [CW-1:0]  FULL      = CW'(REGIONS);

    // Unpack request beat
    logic [ADDR_W-1:0]            in_addr;
    logic [SIZE_W-1:0]            in_size;
    logic [VADDR_BITS+ADDR_W-1:0] addr_ext;
    logic [VADDR_BITS-1:0]        addr_v;
    logic [PW-1:0]                in_page;
    t_func                        in_func;
    logic                         in_fire;

    assign in_addr  = i_s_tdata[47:0];
    assign in_size  = i_s_tdata[95:48];
    assign addr_ext = {VADDR_BITS'(0), in_addr};
    assign addr_v   = addr_ext[VADDR_BITS-1:0];
    assign in_page  = addr_v[VADDR_BITS-1:PAGE_SHIFT];
    assign in_func  = t_func'(i_s_tuser);
    assign in_fire  = i_s_tvalid && o_s_tready;

    // State
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_issue, n_issue;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pend_idx, n_pend_idx;
    logic [FRAME_W-1:0]    r_zero_frame;
    logic                  r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // Held request
    t_func                 r_func;
    logic [PW-1:0]         r_page;
    logic [SW-1:0]         r_sum;
    logic                  r_size_zero;
    logic                  r_writable;
    t_fault_req            r_req;

    // Pending result
    logic                  r_res_status, n_res_status;
    t_action               r_res_action, n_res_action;
    logic [IW-1:0]         r_res_idx, n_res_idx;
    logic [PW-1:0]         r_res_page, n_res_page;
    logic                  r_res_mw, n_res_mw;

    // Region memory: {has_file, write_ok, end page, start page}
    logic                  ram_we, ram_re;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    logic [MW-1:0]         ram_wdata, ram_rdata;

    rtpfc_ram #(
        .WIDTH (MW),
        .DEPTH (REGIONS),
        .AW    (IW)
    ) u_regions (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Round the end up to a page bound and saturate at the top of the range
    logic [SW-1:0]  pad_sum;
    logic [EPW-1:0] end_raw, end_sat;
    logic [EW-1:0]  end_page;

    assign pad_sum  = r_sum + PAGE_MASK;
    assign end_raw  = pad_sum[SW-1:PAGE_SHIFT];
    assign end_sat  = (end_raw > TOP_PAGE) ? TOP_PAGE : end_raw;
    assign end_page = end_sat[EW-1:0];

    // Compare the entry read last cycle against the faulting page
    logic     hit;
    t_verdict verdict;

    rtpfc_decide #(
        .PW (PW)
    ) u_decide (
        .i_page       (r_page),
        .i_start      (ram_rdata[PW-1:0]),
        .i_end        (ram_rdata[PW+EW-1:PW]),
        .i_write_ok   (ram_rdata[PW+EW]),
        .i_has_file   (ram_rdata[PW+EW+1]),
        .i_req        (r_req),
        .i_zero_frame (r_zero_frame),
        .o_hit        (hit),
        .o_verdict    (verdict)
    );

    // Result packing: narrow index and page to their field widths
    logic [IW+IDX_OUT_W-1:0] idx_ext;
    logic [PW+PN_OUT_W-1:0]  pn_ext;

    assign idx_ext = {IDX_OUT_W'(0), r_res_idx};
    assign pn_ext  = {PN_OUT_W'(0), r_res_page};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_res_status = r_res_status;
        n_res_action = r_res_action;
        n_res_idx    = r_res_idx;
        n_res_page   = r_res_page;
        n_res_mw     = r_res_mw;
        n_out_vld    = r_out_vld;
        n_out_data   = r_out_data;
        o_s_tready   = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_count[IW-1:0];
        ram_wdata    = {(r_func == FN_ADD_FILE), r_writable, end_page, r_page};
        ram_re       = 1'b0;
        ram_raddr    = r_issue[IW-1:0];

        // drain the output register
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    unique case (in_func)
                        FN_ADD_ANON, FN_ADD_FILE: begin
                            n_state = S_ADD;
                        end
                        FN_CLEAR: begin
                            n_count      = '0;
                            n_res_status = 1'b0;
                            n_res_action = ACT_TABLE;
                            n_res_idx    = '0;
                            n_res_page   = '0;
                            n_res_mw     = 1'b0;
                            n_state      = S_RESP;
                        end
                        FN_FAULT: begin
                            n_issue = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (r_size_zero || (r_count == FULL)) begin
                    n_res_status = 1'b1;
                    n_res_action = ACT_NONE;
                    n_res_idx    = '0;
                    n_res_page   = '0;
                end else begin
                    ram_we       = 1'b1;
                    n_count      = r_count + CW'(1);
                    n_res_status = 1'b0;
                    n_res_action = ACT_TABLE;
                    n_res_idx    = r_count[IW-1:0];
                    n_res_page   = r_page;
                end
                n_res_mw = 1'b0;
                n_state  = S_RESP;
            end
            S_SCAN: begin
                // issue one read a cycle; check the previous read as it lands
                priority if (r_pend && hit) begin
                    n_res_status = verdict.status;
                    n_res_action = verdict.action;
                    n_res_idx    = r_pend_idx;
                    n_res_page   = r_page;
                    n_res_mw     = verdict.map_writable;
                    n_state      = S_RESP;
                end else if (r_issue == r_count) begin
                    n_res_status = 1'b1;
                    n_res_action = ACT_NO_REGION;
                    n_res_idx    = '0;
                    n_res_page   = r_page;
                    n_res_mw     = 1'b0;
                    n_state      = S_RESP;
                end else begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IW-1:0];
                    n_issue    = r_issue + CW'(1);
                end
            end
            S_RESP: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {2'b00, r_res_mw, pn_ext[PN_OUT_W-1:0],
                                  idx_ext[IDX_OUT_W-1:0], r_res_action, r_res_status};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_issue      <= '0;
            r_pend       <= 1'b0;
            r_out_vld    <= 1'b0;
            r_zero_frame <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_zero_frame <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_res_status <= n_res_status;
        r_res_action <= n_res_action;
        r_res_idx    <= n_res_idx;
        r_res_page   <= n_res_page;
        r_res_mw     <= n_res_mw;
        r_out_data   <= n_out_data;
        if (in_fire) begin
            r_func      <= in_func;
            r_page      <= in_page;
            r_sum       <= SW'(addr_v) + SW'(in_size);
            r_size_zero <= (in_size == '0);
            r_writable  <= i_s_tdata[96];
            r_req       <= '{is_write: i_s_tdata[97],
                             swap:     i_s_tdata[138],
                             mapped:   i_s_tdata[137:98]};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("region count beyond table depth");

    a_write_only_in_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_ADD) && (r_count < FULL))
        else $error("region memory written outside an accepted add");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_issue < r_count))
        else $error("read of a region entry beyond the fill count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_tready)
        else $error("second request taken while one is in work");

    a_load_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) && (!r_out_vld || i_m_tready) |=> o_m_tvalid)
        else $error("result not presented after response state");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rtpfc_pkg::*;

    localparam int N_REGIONS    = REGIONS_DEF;
    localparam int PG_SHIFT     = PAGE_SHIFT_DEF;
    localparam int VPN_W        = VADDR_BITS_DEF - PAGE_SHIFT_DEF;
    // settle time covers the worst fault walk, with a margin on top
    localparam int SETTLE_CYCLES = N_REGIONS + 12;
    localparam bit [FRAME_W-1:0] FRAME_MAX = '1;
    localparam bit [ADDR_W-1:0]  ADDR_MAX  = '1;
    localparam bit [SIZE_W-1:0]  SIZE_MAX  = '1;
    localparam bit [VPN_W:0]     TOP_VPN   = (VPN_W+1)'(1) << VPN_W;
    localparam int unsigned      RANDOM_TARGET = 925;

    typedef struct {
        t_func             func;
        bit [ADDR_W-1:0]   address;
        bit [SIZE_W-1:0]   size;
        bit                writable;
        bit                is_write;
        bit [FRAME_W-1:0]  mapped;
        bit                swap;
    } page_req_t;

    typedef struct {
        bit                 status;
        t_action            action;
        bit [IDX_OUT_W-1:0] region_index;
        bit [PN_OUT_W-1:0]  page_number;
        bit                 map_writable;
    } fault_outcome_t;

    // receiver back-pressure styles
    typedef enum int {RX_OPEN, RX_COIN, RX_BLOCKS, RX_SPARSE} rx_style_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    // address, size, writable, is_write, mapped_frame, swap_slot_present
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    // func
    logic [FUNC_W-1:0]      s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    // status, action, region_index, page_number, map_writable
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en   = 1'b0;
    logic [FRAME_W-1:0]     cfg_wr_data = '0;

    // Shadow of the region table and of the zero-frame register
    bit [VPN_W-1:0]   shadow_start [N_REGIONS];
    bit [VPN_W:0]     shadow_end   [N_REGIONS];
    bit               shadow_wr_ok [N_REGIONS];
    bit               shadow_file  [N_REGIONS];
    int unsigned      shadow_count;
    bit [FRAME_W-1:0] shadow_zero_frame;

    fault_outcome_t   pending_outcomes [$];
    int unsigned      fail_count;
    int unsigned      sent_count;
    int unsigned      burst_left;
    bit               sender_gaps = 1'b1;

    rx_style_t        rx_style;
    int unsigned      rx_left;
    int unsigned      rx_phase;

    always #5 i_clk = ~i_clk;

    region_table_page_fault_classifier_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (m_tdata),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    // Work out the result of one accepted request and advance the shadow table.
    function automatic fault_outcome_t resolve_request(page_req_t rq);
        fault_outcome_t    oc;
        bit [VPN_W-1:0]    vpn;
        bit [ADDR_W+1:0]   end_bytes;
        bit [ADDR_W+1-PG_SHIFT:0] end_pages;
        int                hit;
        int                i;
        vpn = rq.address[ADDR_W-1:PG_SHIFT];
        oc  = '{status: 1'b0, action: ACT_NONE, region_index: '0,
                page_number: '0, map_writable: 1'b0};
        case (rq.func)
            FN_ADD_ANON, FN_ADD_FILE: begin
                if (rq.size == '0 || shadow_count >= N_REGIONS) begin
                    oc.status = 1'b1;
                end else begin
                    // round the end up to a page bound, saturate at the top of the range
                    end_bytes = {2'b00, rq.address} + {2'b00, rq.size}
                              + ((ADDR_W+2)'(1) << PG_SHIFT) - 1;
                    end_pages = end_bytes[ADDR_W+1:PG_SHIFT];
                    if (end_pages > TOP_VPN)
                        end_pages = TOP_VPN;
                    shadow_start[shadow_count] = vpn;
                    shadow_end[shadow_count]   = end_pages[VPN_W:0];
                    shadow_wr_ok[shadow_count] = rq.writable;
                    shadow_file[shadow_count]  = (rq.func == FN_ADD_FILE);
                    oc.action       = ACT_TABLE;
                    oc.region_index = IDX_OUT_W'(shadow_count);
                    oc.page_number  = vpn;
                    shadow_count++;
                end
            end
            FN_CLEAR: begin
                shadow_count = 0;
                oc.action    = ACT_TABLE;
            end
            default: begin
                hit = -1;
                for (i = 0; i < shadow_count; i++)
                    if (hit < 0 && vpn >= shadow_start[i] && vpn < shadow_end[i])
                        hit = i;
                oc.page_number = vpn;
                if (hit < 0) begin
                    oc.status = 1'b1;
                    oc.action = ACT_NO_REGION;
                end else begin
                    oc.region_index = IDX_OUT_W'(hit);
                    if (rq.mapped == '0) begin
                        oc.map_writable = shadow_wr_ok[hit];
                        if (rq.swap) begin
                            oc.action = ACT_SWAP_IN;
                        end else if (shadow_file[hit]) begin
                            oc.action = ACT_FILE_FILL;
                        end else if (!rq.is_write) begin
                            oc.action       = ACT_SHARE_ZERO;
                            oc.map_writable = 1'b0;
                        end else begin
                            oc.action = ACT_FRESH;
                        end
                    end else if (rq.is_write && rq.mapped == shadow_zero_frame
                                 && shadow_wr_ok[hit]) begin
                        oc.action       = ACT_COW;
                        oc.map_writable = 1'b1;
                    end else begin
                        oc.status = 1'b1;
                        oc.action = ACT_REFUSED;
                    end
                end
            end
        endcase
        return oc;
    endfunction

    function automatic page_req_t page_op(t_func func, bit [ADDR_W-1:0] address,
                                          bit [SIZE_W-1:0] size, bit writable,
                                          bit is_write, bit [FRAME_W-1:0] mapped,
                                          bit swap);
        page_req_t rq;
        rq = '{func: func, address: address, size: size, writable: writable,
               is_write: is_write, mapped: mapped, swap: swap};
        return rq;
    endfunction

    // Present one request beat, hold it until taken, then record its expected result.
    // Called and returns at a falling edge; leaves tvalid high inside a burst.
    task automatic send_req(page_req_t rq);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[47:0]   = rq.address;
        beat[95:48]  = rq.size;
        beat[96]     = rq.writable;
        beat[97]     = rq.is_write;
        beat[137:98] = rq.mapped;
        beat[138]    = rq.swap;
        s_tdata  = beat;
        s_tuser  = rq.func;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        // push at the falling edge so the checker never races the queue
        @(negedge i_clk);
        pending_outcomes.push_back(resolve_request(rq));
        sent_count++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps && $urandom_range(0, 3) != 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Drop tvalid and wait until every expected beat has come out, then let the
    // block fall quiet.
    task automatic settle_outputs();
        s_tvalid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_zero_frame(bit [FRAME_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge i_clk);
        cfg_wr_en         = 1'b0;
        shadow_zero_frame = value;
    endtask

    task automatic check_field(string name, bit [63:0] want, bit [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        fault_outcome_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status",       want.status,       m_tdata[0]);
                check_field("action",       want.action,       m_tdata[4:1]);
                check_field("region_index", want.region_index, m_tdata[8:5]);
                check_field("page_number",  want.page_number,  m_tdata[44:9]);
                check_field("map_writable", want.map_writable, m_tdata[45]);
                check_field("padding",      '0, m_tdata[OUT_TDATA_W-1:46]);
            end
        end
    end

    // Receiver back-pressure: switch between styles at random intervals,
    // including long stretches of full readiness.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_left  = $urandom_range(40, 300);
            rx_phase = 0;
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_BLOCKS: m_tready <= (rx_phase % 29) < 17;
            default:   m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Clear, fault, adds: zero size, odd start, saturating end, read-only, file-backed.
    task automatic test_table_edits();
        write_zero_frame(FRAME_MAX);
        send_req(page_op(FN_CLEAR, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        send_req(page_op(FN_FAULT, ADDR_MAX, '0, 1'b0, 1'b1, '0, 1'b0));
        send_req(page_op(FN_ADD_ANON, 48'h1234, '0, 1'b1, 1'b0, '0, 1'b0));
        send_req(page_op(FN_ADD_ANON, 48'h1234, 48'd1, 1'b1, 1'b0, '0, 1'b0));
        send_req(page_op(FN_ADD_FILE, 48'h10000, 48'h3000, 1'b0, 1'b0, '0, 1'b0));
        send_req(page_op(FN_ADD_ANON, 48'hFFFF_FFFF_F000, SIZE_MAX, 1'b1, 1'b0,
                         '0, 1'b0));
        send_req(page_op(FN_ADD_ANON, 48'h100000, 48'h10000, 1'b0, 1'b0, '0, 1'b0));
    endtask

    // Faults that reach every fault action, some more than once, on the table built above.
    task automatic test_fault_actions();
        send_req(page_op(FN_FAULT, 48'h1FFF,  '0, 1'b0, 1'b0, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000,  '0, 1'b0, 1'b1, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000,  '0, 1'b0, 1'b0, '0, 1'b1));
        send_req(page_op(FN_FAULT, 48'h10ABC, '0, 1'b0, 1'b1, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h12FFF, '0, 1'b0, 1'b1, FRAME_MAX, 1'b0));
        // first page past a region's end
        send_req(page_op(FN_FAULT, 48'h13000, '0, 1'b0, 1'b0, '0, 1'b0));
        // write to an absent page of a read-only anonymous region
        send_req(page_op(FN_FAULT, 48'h100000, '0, 1'b0, 1'b1, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000, '0, 1'b0, 1'b1, FRAME_MAX, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000, '0, 1'b0, 1'b0, FRAME_MAX, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000, '0, 1'b0, 1'b1, 40'd1, 1'b0));
        send_req(page_op(FN_FAULT, ADDR_MAX, '0, 1'b0, 1'b1, FRAME_MAX, 1'b0));
        send_req(page_op(FN_FAULT, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    endtask

    // Overlapping regions resolve to the first entry; a clear empties the table.
    task automatic test_overlap_and_clear();
        send_req(page_op(FN_ADD_FILE, '0, SIZE_MAX, 1'b1, 1'b0, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h1000, '0, 1'b0, 1'b1, '0, 1'b0));
        send_req(page_op(FN_FAULT, 48'h5000, '0, 1'b0, 1'b0, '0, 1'b0));
        send_req(page_op(FN_ADD_FILE, 48'h2000, '0, 1'b1, 1'b0, '0, 1'b0));
        send_req(page_op(FN_CLEAR, ADDR_MAX, SIZE_MAX, 1'b1, 1'b1, FRAME_MAX, 1'b1));
        send_req(page_op(FN_FAULT, 48'h1000, '0, 1'b0, 1'b1, '0, 1'b0));
        settle_outputs();
    endtask

    // Sessions: settle, set the zero frame, build a table, then fault mostly inside
    // it, with some noise mixed in. Now and then overfill the table.
    task automatic test_random_sessions();
        page_req_t         rq;
        int unsigned       n_add;
        int unsigned       n_fault;
        int unsigned       idx;
        int unsigned       k;
        bit [VPN_W-1:0]    base;
        bit [VPN_W-1:0]    vpn;
        bit [VPN_W:0]      span;
        while (sent_count < RANDOM_TARGET) begin
            settle_outputs();
            case ($urandom_range(0, 4))
                0:       write_zero_frame('0);
                1:       write_zero_frame(FRAME_MAX);
                2:       write_zero_frame(FRAME_W'($urandom_range(1, 255)));
                default: write_zero_frame(FRAME_W'({$urandom(), $urandom()}));
            endcase
            sender_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) != 0)
                send_req(page_op(FN_CLEAR, '0, '0, 1'b0, 1'b0, '0, 1'b0));
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1 - VPN_W'($urandom_range(0, 40));
                default: base = VPN_W'({$urandom(), $urandom()});
            endcase
            n_add = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20)
                                                 : $urandom_range(1, 6);
            for (k = 0; k < n_add; k++) begin
                rq = page_op($urandom_range(0, 1) ? FN_ADD_FILE : FN_ADD_ANON,
                             {base + VPN_W'($urandom_range(0, 48)),
                              PG_SHIFT'($urandom())},
                             SIZE_W'($urandom_range(1, 16 << PG_SHIFT)),
                             1'($urandom()), 1'($urandom()),
                             FRAME_W'({$urandom(), $urandom()}), 1'($urandom()));
                case ($urandom_range(0, 11))
                    0:       rq.size = '0;
                    1:       rq.size = SIZE_W'({$urandom(), $urandom()});
                    default: ;
                endcase
                send_req(rq);
            end
            n_fault = $urandom_range(10, 40);
            for (k = 0; k < n_fault; k++) begin
                rq = page_op(t_func'($urandom_range(0, 3)),
                             ADDR_W'({$urandom(), $urandom()}),
                             SIZE_W'({$urandom(), $urandom()}),
                             1'($urandom()), 1'($urandom()),
                             FRAME_W'({$urandom(), $urandom()}), 1'($urandom()));
                // one in ten beats stays pure noise
                if ($urandom_range(0, 9) != 0) begin
                    rq.func = FN_FAULT;
                    if (shadow_count > 0 && $urandom_range(0, 7) != 0) begin
                        idx  = $urandom_range(0, shadow_count - 1);
                        span = shadow_end[idx] - shadow_start[idx];
                        case ($urandom_range(0, 7))
                            0:       vpn = shadow_start[idx] - 1;
                            1:       vpn = shadow_end[idx][VPN_W-1:0];
                            2:       vpn = shadow_start[idx];
                            3:       vpn = shadow_end[idx][VPN_W-1:0] - 1;
                            default: vpn = shadow_start[idx]
                                         + VPN_W'({$urandom(), $urandom()} % span);
                        endcase
                    end else begin
                        vpn = base + VPN_W'($urandom_range(0, 80));
                    end
                    rq.address = {vpn, PG_SHIFT'($urandom())};
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: rq.mapped = '0;
                        4, 5, 6:    rq.mapped = shadow_zero_frame;
                        default:    ;
                    endcase
                    rq.swap = ($urandom_range(0, 3) == 0);
                end
                send_req(rq);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_table_edits();
        test_fault_actions();
        test_overlap_and_clear();
        test_random_sessions();
        settle_outputs();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/rtpfc_pkg.sv
src/rtpfc_ram.sv
src/rtpfc_decide.sv
src/region_table_page_fault_classifier_top.sv
tb/tb.sv
